// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define SPB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define SPB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/spb_pkg.sv =====
// shared types and constants of the serial clock prescaler search
package spb_pkg;

   localparam int MAX_PRESCALE_DEF = 15;
   localparam int MAX_EXPONENT_DEF = 7;

   localparam int CORE_W      = 32;
   localparam int DIV_CNT_W   = $clog2(CORE_W);
   localparam int TARGET_W    = 31;
   localparam int SLAVE_W     = 4;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int PRESCALE_W  = 4;
   localparam int EXPONENT_W  = 3;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;
   localparam int REQ_FIELD_W = TARGET_W + SLAVE_W + MODE_W;
   localparam int RSP_FIELD_W = STATUS_W + PRESCALE_W + EXPONENT_W + 3;

   localparam logic [CORE_W-1:0]  CORE_CLOCK_RESET = 32'd200000000;
   localparam logic [SLAVE_W-1:0] SLAVE_MAX        = 4'd7;
   localparam logic [MODE_W-1:0]  MODE_MAX         = 3'd3;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_SLAVE = 2'd1,
      ST_BAD_MODE  = 2'd2,
      ST_NO_PAIR   = 2'd3
   } spb_code_type;

   typedef struct packed {
      logic [MODE_W-1:0]   clock_mode;
      logic [SLAVE_W-1:0]  slave_number;
      logic [TARGET_W-1:0] target_rate_hz;
   } spb_request_type;

   typedef struct packed {
      spb_code_type          status;
      logic [PRESCALE_W-1:0] prescale;
      logic [EXPONENT_W-1:0] exponent;
      logic                  exact_hit;
      logic                  clock_polarity;
      logic                  clock_phase;
   } spb_result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } spb_ctrl_type;

   typedef struct packed {
      logic              start;
      logic [CORE_W-1:0] dividend;
   } spb_div_req_type;

   typedef struct packed {
      logic              done;
      logic [CORE_W-1:0] quotient;
   } spb_div_rsp_type;

endpackage

// ===== rtl/core/spb_divider.sv =====
// shared restoring divider, one quotient bit per cycle
module spb_divider #(
   parameter int DIVISOR_W = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spb_pkg::spb_div_req_type div_req,
   input  logic [DIVISOR_W-1:0]     divisor,
   output spb_pkg::spb_div_rsp_type div_rsp
);

   localparam int CW = spb_pkg::CORE_W;
   localparam int NW = spb_pkg::DIV_CNT_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[CW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[CW-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(CW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/spb_search.sv =====
// prescale and exponent search sequencer around the shared divider
module spb_search #(
   parameter int MAX_PRESCALE = spb_pkg::MAX_PRESCALE_DEF,
   parameter int MAX_EXPONENT = spb_pkg::MAX_EXPONENT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  spb_pkg::spb_request_type        req,
   input  logic [spb_pkg::CORE_W-1:0]      core_clock_hz,
   input  logic                            take,
   output spb_pkg::spb_ctrl_type           ctrl,
   output spb_pkg::spb_result_type         result
);

   localparam int PRE_W = (MAX_PRESCALE > 1) ? $clog2(MAX_PRESCALE + 1) : 1;
   localparam int EXP_W = (MAX_EXPONENT > 0) ? $clog2(MAX_EXPONENT + 1) : 1;
   localparam int CW    = spb_pkg::CORE_W;
   localparam int TW    = spb_pkg::TARGET_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   spb_pkg::spb_code_type        status_ff, status_in;
   logic [TW-1:0]                target_ff, target_in;
   logic [spb_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [PRE_W-1:0]             pre_ff, pre_in;
   logic [EXP_W-1:0]             ex_ff, ex_in;
   logic [CW-1:0]                rate_ff, rate_in;
   logic [TW-1:0]                best_rate_ff, best_rate_in;
   logic [PRE_W-1:0]             best_pre_ff, best_pre_in;
   logic [EXP_W-1:0]             best_ex_ff, best_ex_in;
   logic                         found_ff, found_in;
   logic                         exact_ff, exact_in;

   spb_pkg::spb_div_req_type     div_req;
   spb_pkg::spb_div_rsp_type     div_rsp;
   logic [PRE_W-1:0]             divisor;

   logic [CW-1:0]                target_ext;
   logic                         rate_eq;
   logic                         rate_below;
   logic                         rate_better;
   logic                         ok;

   spb_divider #(
      .DIVISOR_W (PRE_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (divisor),
      .div_rsp (div_rsp)
   );

   assign target_ext  = {1'b0, target_ff};
   assign rate_eq     = rate_ff == target_ext;
   assign rate_below  = rate_ff < target_ext;
   assign rate_better = !found_ff || (rate_ff[TW-1:0] > best_rate_ff);

   always_comb begin
      state_in         = state_ff;
      status_in        = status_ff;
      target_in        = target_ff;
      mode_in          = mode_ff;
      pre_in           = pre_ff;
      ex_in            = ex_ff;
      rate_in          = rate_ff;
      best_rate_in     = best_rate_ff;
      best_pre_in      = best_pre_ff;
      best_ex_in       = best_ex_ff;
      found_in         = found_ff;
      exact_in         = exact_ff;
      div_req.start    = 1'b0;
      div_req.dividend = core_clock_hz;
      divisor          = PRE_W'(1);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               target_in    = req.target_rate_hz;
               mode_in      = req.clock_mode;
               found_in     = 1'b0;
               exact_in     = 1'b0;
               best_rate_in = '0;
               best_pre_in  = '0;
               best_ex_in   = '0;
               pre_in       = PRE_W'(1);
               ex_in        = '0;
               if (req.slave_number > spb_pkg::SLAVE_MAX) begin
                  status_in = spb_pkg::ST_BAD_SLAVE;
                  state_in  = S_DONE;
               end else if (req.clock_mode > spb_pkg::MODE_MAX) begin
                  status_in = spb_pkg::ST_BAD_MODE;
                  state_in  = S_DONE;
               end else begin
                  status_in     = spb_pkg::ST_OK;
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               rate_in  = div_rsp.quotient;
               ex_in    = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rate_eq) begin
               best_pre_in = pre_ff;
               best_ex_in  = ex_ff;
               found_in    = 1'b1;
               exact_in    = 1'b1;
               state_in    = S_DONE;
            end else begin
               if (rate_below && rate_better) begin
                  found_in     = 1'b1;
                  best_rate_in = rate_ff[TW-1:0];
                  best_pre_in  = pre_ff;
                  best_ex_in   = ex_ff;
               end
               if (ex_ff == EXP_W'(MAX_EXPONENT)) begin
                  if (pre_ff == PRE_W'(MAX_PRESCALE)) begin
                     state_in = S_DONE;
                  end else begin
                     pre_in        = pre_ff + 1'b1;
                     divisor       = pre_ff + 1'b1;
                     div_req.start = 1'b1;
                     state_in      = S_DIV;
                  end
               end else begin
                  ex_in   = ex_ff + 1'b1;
                  rate_in = rate_ff >> 1;
               end
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff    <= status_in;
      target_ff    <= target_in;
      mode_ff      <= mode_in;
      pre_ff       <= pre_in;
      ex_ff        <= ex_in;
      rate_ff      <= rate_in;
      best_rate_ff <= best_rate_in;
      best_pre_ff  <= best_pre_in;
      best_ex_ff   <= best_ex_in;
      found_ff     <= found_in;
      exact_ff     <= exact_in;
   end

   assign ok = (status_ff == spb_pkg::ST_OK) && found_ff;

   always_comb begin
      if (status_ff != spb_pkg::ST_OK) begin
         result.status = status_ff;
      end else if (found_ff) begin
         result.status = spb_pkg::ST_OK;
      end else begin
         result.status = spb_pkg::ST_NO_PAIR;
      end
      result.prescale       = ok ? spb_pkg::PRESCALE_W'(best_pre_ff) : '0;
      result.exponent       = ok ? spb_pkg::EXPONENT_W'(best_ex_ff) : '0;
      result.exact_hit      = ok & exact_ff;
      result.clock_polarity = ok & mode_ff[1];
      result.clock_phase    = ok & mode_ff[0];
   end

   assign ctrl.idle = state_ff == S_IDLE;
   assign ctrl.done = state_ff == S_DONE;

endmodule

// ===== rtl/core/spi_baud_prescaler_search.sv =====
// Serial clock prescaler search, top level. Each request word runs alone: req_tready is high
// only while no search is in progress, and a finished result waits in the output register
// so the next word can be taken meanwhile. A rejected slave or mode answers without a
// division. A full search runs the single shared divider on core_clock_hz / prescale for
// each prescale value, followed by one compare and one-bit shift per exponent value, and
// stops early on an exact match.
module spi_baud_prescaler_search #(
   parameter int MAX_PRESCALE = spb_pkg::MAX_PRESCALE_DEF,
   parameter int MAX_EXPONENT = spb_pkg::MAX_EXPONENT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [spb_pkg::CORE_W-1:0]      csr_wr_data,  // core_clock_hz
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // target_rate_hz[30:0], slave_number[34:31], clock_mode[37:35], zero fill
   input  logic [spb_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], prescale[5:2], exponent[8:6], exact_hit[9],
   // clock_polarity[10], clock_phase[11], zero fill
   output logic [spb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [spb_pkg::CORE_W-1:0]      core_clock_ff, core_clock_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [spb_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   spb_pkg::spb_request_type        req;
   spb_pkg::spb_result_type         result;
   spb_pkg::spb_ctrl_type           ctrl;
   logic                            start;
   logic                            take;

   assign req   = spb_pkg::spb_request_type'(req_tdata[spb_pkg::REQ_FIELD_W-1:0]);
   assign start = req_tvalid && ctrl.idle;
   assign take  = ctrl.done && (!rsp_valid_ff || rsp_tready);

   spb_search #(
      .MAX_PRESCALE (MAX_PRESCALE),
      .MAX_EXPONENT (MAX_EXPONENT)
   ) u_search (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req           (req),
      .core_clock_hz (core_clock_ff),
      .take          (take),
      .ctrl          (ctrl),
      .result        (result)
   );

   always_comb begin
      core_clock_in = csr_wr_en ? csr_wr_data : core_clock_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {
            (spb_pkg::RSP_TDATA_W - spb_pkg::RSP_FIELD_W)'(0),
            result.clock_phase,
            result.clock_polarity,
            result.exact_hit,
            result.exponent,
            result.prescale,
            result.status
         };
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_clock_ff <= spb_pkg::CORE_CLOCK_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         core_clock_ff <= core_clock_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = ctrl.idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/spb_checker.sv =====
// port-level checker for the prescaler search and its bind
`include "assert_macros.svh"

module spb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [spb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic status_ok;

   assign status_ok = rsp_tdata[1:0] == spb_pkg::ST_OK;

   `SPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SPB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SPB_ASSERT_IMPLY(a_error_zeroed, clock, reset, rsp_tvalid && !status_ok, rsp_tdata[11:2] == 10'd0)
   `SPB_ASSERT_IMPLY(a_exact_is_ok, clock, reset, rsp_tvalid && rsp_tdata[9], status_ok)

endmodule

bind spi_baud_prescaler_search spb_checker u_spb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
